@@ hdl/aes256_ctr_keystream_unit_assert.svh @@
// Assertion macros for the AES-256 counter-mode keystream unit.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef AES256_CTR_KEYSTREAM_UNIT_ASSERT_SVH
`define AES256_CTR_KEYSTREAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ACK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ACK_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACK_ASSERT(label, clk, rst, prop, msg)
`define ACK_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ hdl/ack_pkg.sv @@
// Package for the AES-256 counter-mode keystream unit: payload types, codes,
// the S-box table and round helper functions. No dependencies.
`timescale 1ns / 1ps
package ack_pkg;

   typedef enum logic [1:0] {
      OP_KEY_LOAD = 2'd0,
      OP_ENCRYPT  = 2'd1,
      OP_CTR_RUN  = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   localparam int unsigned KEY_ROUNDS  = 14;
   localparam int unsigned KEY_ENTRIES = 2 * (KEY_ROUNDS + 1);
   localparam int unsigned KEY_ADDR_W  = 5;
   localparam int unsigned ROUND_W     = 4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  key_index;
      logic        key_half;
      logic [63:0] data_hi;
      logic [63:0] data_lo;
      logic [6:0]  block_count;
   } req_type;

   typedef struct packed {
      logic [63:0] block_hi;
      logic [63:0] block_lo;
      logic        last_block;
   } rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the state is bits 127-8i down to 120-8i; byte 4c+r is row r of column c.
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, all;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
         t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
         t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
         t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
      end
      mix_columns = t;
   endfunction

endpackage

@@ hdl/ack_front.sv @@
// Front end of the keystream unit: accepts transactions, sends key loads into the
// key write path, drops unused codes and queues block jobs. Uses ack_pkg.
`timescale 1ns / 1ps
module ack_front
   import ack_pkg::*;
#(
   parameter int unsigned MAX_RUN = 64,
   parameter int unsigned CNT_W   = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  key_we,
   output logic [KEY_ADDR_W-1:0] key_waddr,
   output logic [63:0]           key_wdata,
   output logic                  job_valid,
   input  logic                  job_ready,
   output logic [127:0]          job_block,
   output logic [CNT_W-1:0]      job_count
);

   localparam int unsigned DEPTH = 2;

   logic [127:0]     blk_ff   [DEPTH];
   logic [CNT_W-1:0] cnt_ff   [DEPTH];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       fill_ff, fill_in;
   logic             acc, is_job, pop;
   logic [CNT_W-1:0] sat_cnt;

   // A key load waits until every earlier transaction has left the engine.
   assign req_ready = (fill_ff != 2'(DEPTH)) &&
                      ((req_data.operation != OP_KEY_LOAD) ||
                       ((fill_ff == 2'd0) && job_ready));
   assign acc       = req_valid && req_ready;
   assign sat_cnt   = (32'(req_data.block_count) > MAX_RUN) ? CNT_W'(MAX_RUN)
                                                            : CNT_W'(req_data.block_count);
   assign is_job    = (req_data.operation == OP_ENCRYPT) ||
                      ((req_data.operation == OP_CTR_RUN) && (req_data.block_count != 7'd0));
   assign key_we    = acc && (req_data.operation == OP_KEY_LOAD) &&
                      (32'(req_data.key_index) <= KEY_ROUNDS);
   assign key_waddr = {req_data.key_index, req_data.key_half};
   assign key_wdata = req_data.data_hi;

   assign job_valid = (fill_ff != 2'd0);
   assign job_block = blk_ff[rd_ff];
   assign job_count = cnt_ff[rd_ff];
   assign pop       = job_valid && job_ready;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (acc && is_job) begin
         wr_in   = ~wr_ff;
         fill_in = fill_in + 2'd1;
      end
      if (pop) begin
         rd_in   = ~rd_ff;
         fill_in = fill_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (acc && is_job) begin
         blk_ff[wr_ff] <= {req_data.data_hi, req_data.data_lo};
         cnt_ff[wr_ff] <= (req_data.operation == OP_ENCRYPT) ? CNT_W'(0) : sat_cnt;
      end
   end

`include "aes256_ctr_keystream_unit_assert.svh"
   `ACK_ASSERT(a_fill_bound, clock, reset, fill_ff <= 2'(DEPTH), "queue overfilled")
   `ACK_ASSERT(a_no_push_full, clock, reset, (fill_ff == 2'(DEPTH)) |-> !acc, "push when full")
   `ACK_ASSERT(a_pop_count, clock, reset, (pop && !(acc && is_job)) |=> fill_ff == $past(fill_ff) - 2'd1, "pop count")

endmodule

@@ hdl/ack_back.sv @@
// Back end of the keystream unit: the round key memory and one shared round
// unit that runs each queued job block by block. Uses ack_pkg.
`timescale 1ns / 1ps
module ack_back
   import ack_pkg::*;
#(
   parameter int unsigned CNT_W = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  key_we,
   input  logic [KEY_ADDR_W-1:0] key_waddr,
   input  logic [63:0]           key_wdata,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  logic [127:0]          job_block,
   input  logic [CNT_W-1:0]      job_count,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_ROUND, ST_OUT} state_type;

   logic [63:0]        mem_hi [KEY_ROUNDS + 1];
   logic [63:0]        mem_lo [KEY_ROUNDS + 1];
   logic [127:0]       rk_ff;
   logic [ROUND_W-1:0] rd_addr;

   state_type          state_ff;
   logic [ROUND_W-1:0] round_ff;
   logic [127:0]       st_ff, base_ff;
   logic [CNT_W-1:0]   left_ff;
   logic               single_ff;
   logic               rvalid_ff;
   rsp_type            rdata_ff;
   logic [127:0]       sb, after;
   logic [31:0]        ctr_next;

   always_ff @(posedge clock) begin
      if (key_we) begin
         if (key_waddr[0]) mem_lo[key_waddr[KEY_ADDR_W-1:1]] <= key_wdata;
         else              mem_hi[key_waddr[KEY_ADDR_W-1:1]] <= key_wdata;
      end
      rk_ff <= {mem_hi[rd_addr], mem_lo[rd_addr]};
   end

   assign sb       = sub_shift(st_ff);
   assign after    = ((round_ff == ROUND_W'(KEY_ROUNDS)) ? sb : mix_columns(sb)) ^ rk_ff;
   assign ctr_next = base_ff[31:0] + 32'd1;
   assign job_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rdata_ff;

   // The key memory read is registered: the address is set for the next cycle's round.
   always_comb begin
      rd_addr = '0;
      if (state_ff == ST_FETCH) begin
         rd_addr = ROUND_W'(1);
      end else if ((state_ff == ST_ROUND) && (round_ff != ROUND_W'(KEY_ROUNDS))) begin
         rd_addr = round_ff + ROUND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
         round_ff  <= '0;
      end else begin
         if (rvalid_ff && rsp_ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  base_ff   <= job_block;
                  left_ff   <= job_count;
                  single_ff <= (job_count == '0);
                  state_ff  <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               st_ff    <= base_ff ^ rk_ff;
               round_ff <= ROUND_W'(1);
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (round_ff == ROUND_W'(KEY_ROUNDS)) begin
                  st_ff    <= after;
                  state_ff <= ST_OUT;
               end else begin
                  st_ff    <= after;
                  round_ff <= round_ff + ROUND_W'(1);
               end
            end
            ST_OUT: begin
               if (!rvalid_ff || rsp_ready) begin
                  rvalid_ff           <= 1'b1;
                  rdata_ff.block_hi   <= st_ff[127:64];
                  rdata_ff.block_lo   <= st_ff[63:0];
                  rdata_ff.last_block <= single_ff || (left_ff == CNT_W'(1));
                  if (single_ff || (left_ff == CNT_W'(1))) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     left_ff  <= left_ff - CNT_W'(1);
                     base_ff  <= {base_ff[127:32], ctr_next};
                     state_ff <= ST_FETCH;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`include "aes256_ctr_keystream_unit_assert.svh"
   `ACK_ASSERT(a_hold_rsp, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data), "response dropped")
   `ACK_ASSERT(a_round_range, clock, reset, (state_ff == ST_ROUND) |-> (round_ff != '0), "bad round")
   `ACK_ASSERT(a_take_idle, clock, reset, (job_valid && job_ready) |=> state_ff == ST_FETCH, "job lost")

endmodule

@@ hdl/aes256_ctr_keystream_unit.sv @@
// Top level of the AES-256 counter-mode keystream unit: front end, job queue
// and round engine. Uses ack_pkg, ack_front and ack_back.
//
//  channel  direction  payload   handshake
//  req      in         req_type  req_valid / req_ready
//  rsp      out        rsp_type  rsp_valid / rsp_ready
//
// Each block passes through the shared round unit as the initial key addition, the
// 14 rounds and an output step; taking a job from the queue adds an idle step first.
// A key load waits until the queue is empty and the engine idle, then writes at acceptance.
// A two-entry job queue lets requests enter while the engine works; a stalled response
// halts the engine. Reset is synchronous and clears control state only; keys stay undefined.
`timescale 1ns / 1ps
module aes256_ctr_keystream_unit
   import ack_pkg::*;
#(
   parameter int unsigned MAX_RUN = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned CNT_W = $clog2(MAX_RUN + 1);

   logic                  key_we;
   logic [KEY_ADDR_W-1:0] key_waddr;
   logic [63:0]           key_wdata;
   logic                  job_valid, job_ready;
   logic [127:0]          job_block;
   logic [CNT_W-1:0]      job_count;

   ack_front #(.MAX_RUN(MAX_RUN), .CNT_W(CNT_W)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .key_we, .key_waddr, .key_wdata,
      .job_valid, .job_ready, .job_block, .job_count
   );

   ack_back #(.CNT_W(CNT_W)) u_back (
      .clock, .reset, .key_we, .key_waddr, .key_wdata,
      .job_valid, .job_ready, .job_block, .job_count,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule
